// ===== rtl/cbm68_pkg.sv =====
// shared types and constants for the bank mapper
// action and target codes, write decode, bank register bundle
package cbm68_pkg;

  typedef enum logic [1:0] {
    ACT_CPU_WRITE = 2'd0,
    ACT_PPU_READ  = 2'd1,
    ACT_CPU_READ  = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    TGT_NONE = 2'd0,
    TGT_PRG  = 2'd1,
    TGT_CHR  = 2'd2,
    TGT_CIRAM = 2'd3
  } target_t;

  typedef enum logic [1:0] {
    MIR_VERTICAL   = 2'd0,
    MIR_HORIZONTAL = 2'd1,
    MIR_SINGLE_0   = 2'd2,
    MIR_SINGLE_1   = 2'd3
  } mirror_t;

  // register select on cpu address bits 14..12 (bit 15 set)
  localparam logic [2:0] REG_CHR0  = 3'd0;
  localparam logic [2:0] REG_CHR1  = 3'd1;
  localparam logic [2:0] REG_CHR2  = 3'd2;
  localparam logic [2:0] REG_CHR3  = 3'd3;
  localparam logic [2:0] REG_NT_A  = 3'd4;
  localparam logic [2:0] REG_NT_B  = 3'd5;
  localparam logic [2:0] REG_CTRL  = 3'd6;
  localparam logic [2:0] REG_PRG   = 3'd7;

  localparam logic [7:0] LAST_PRG_RESET = 8'd7;
  localparam logic [5:0] PALETTE_PAGE   = 6'h3F;
  localparam logic [8:0] NT_ROM_OFFSET  = 9'h080;

  localparam int ROM_W = 22;
  localparam int RAM_W = 11;

  typedef struct packed {
    logic [3:0][7:0] chr_bank;
    logic [7:0]      nt_bank_a;
    logic [7:0]      nt_bank_b;
    logic            nt_from_rom;
    mirror_t         mirror;
    logic [7:0]      prg_bank;
    logic [7:0]      last_prg_bank;
  } bank_state_t;

  typedef struct packed {
    target_t            target;
    logic [ROM_W-1:0]   rom_address;
    logic [RAM_W-1:0]   ram_address;
  } result_t;

endpackage

// ===== rtl/cbm68_regs.sv =====
// bank and control registers with cpu write decode
// depends on cbm68_pkg
module cbm68_regs (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [15:0]           wr_addr,
  input  logic [7:0]            wr_data,
  input  logic                  cfg_wr_en,
  input  logic [7:0]            cfg_wr_data,
  output cbm68_pkg::bank_state_t state
);
  import cbm68_pkg::*;

  logic [3:0][7:0] chr_bank_r;
  logic [7:0]      nt_bank_a_r;
  logic [7:0]      nt_bank_b_r;
  logic            nt_from_rom_r;
  mirror_t         mirror_r;
  logic [7:0]      prg_bank_r;
  logic [7:0]      last_prg_r;
  logic            hit;

  assign hit = wr_en && wr_addr[15];

  // pattern and program banks hold no reset value
  always_ff @(posedge clk) begin
    if (hit) begin
      unique case (wr_addr[14:12])
        REG_CHR0, REG_CHR1, REG_CHR2, REG_CHR3: chr_bank_r[wr_addr[13:12]] <= wr_data;
        REG_PRG: prg_bank_r <= wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nt_bank_a_r   <= '0;
      nt_bank_b_r   <= '0;
      nt_from_rom_r <= 1'b0;
      mirror_r      <= MIR_VERTICAL;
    end else if (hit) begin
      unique case (wr_addr[14:12])
        REG_NT_A: nt_bank_a_r <= wr_data;
        REG_NT_B: nt_bank_b_r <= wr_data;
        REG_CTRL: begin
          nt_from_rom_r <= wr_data[4];
          mirror_r      <= mirror_t'(wr_data[1:0]);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_prg_r <= LAST_PRG_RESET;
    end else if (cfg_wr_en) begin
      last_prg_r <= cfg_wr_data;
    end
  end

  assign state.chr_bank      = chr_bank_r;
  assign state.nt_bank_a     = nt_bank_a_r;
  assign state.nt_bank_b     = nt_bank_b_r;
  assign state.nt_from_rom   = nt_from_rom_r;
  assign state.mirror        = mirror_r;
  assign state.prg_bank      = prg_bank_r;
  assign state.last_prg_bank = last_prg_r;

endmodule

// ===== rtl/cbm68_lookup.sv =====
// address translation for cpu and ppu lookups
// depends on cbm68_pkg
module cbm68_lookup (
  input  cbm68_pkg::action_t     action,
  input  logic [15:0]            address,
  input  cbm68_pkg::bank_state_t state,
  output cbm68_pkg::result_t     result
);
  import cbm68_pkg::*;

  logic [13:0] ppu_a;
  logic        second;
  logic [7:0]  nt_reg;
  logic [8:0]  nt_rom_bank;
  logic [7:0]  prg_sel;

  assign ppu_a = address[13:0];

  always_comb begin
    unique case (state.mirror)
      MIR_VERTICAL:   second = ppu_a[10];
      MIR_HORIZONTAL: second = ppu_a[11];
      MIR_SINGLE_0:   second = 1'b0;
      MIR_SINGLE_1:   second = 1'b1;
      default:        second = 1'b0;
    endcase
  end

  assign nt_reg      = second ? state.nt_bank_b : state.nt_bank_a;
  assign nt_rom_bank = {1'b0, nt_reg} + NT_ROM_OFFSET;
  assign prg_sel     = address[14] ? state.last_prg_bank : state.prg_bank;

  always_comb begin
    result = '{target: TGT_NONE, rom_address: '0, ram_address: '0};
    unique case (action)
      ACT_PPU_READ: begin
        if (!ppu_a[13]) begin
          result.target      = TGT_CHR;
          result.rom_address = {3'b000, state.chr_bank[ppu_a[12:11]], ppu_a[10:0]};
        end else if (ppu_a[13:8] != PALETTE_PAGE) begin
          if (state.nt_from_rom) begin
            result.target      = TGT_CHR;
            result.rom_address = {3'b000, nt_rom_bank, ppu_a[9:0]};
          end else begin
            result.target      = TGT_CIRAM;
            result.ram_address = {second, ppu_a[9:0]};
          end
        end
      end
      ACT_CPU_READ: begin
        if (address[15]) begin
          result.target      = TGT_PRG;
          result.rom_address = {prg_sel, address[13:0]};
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/cartridge_bank_mapper_68.sv =====
// One word per clock while the output is not stalled: a word is held in the input register,
// is decoded and translated there, and its result lands in the output register,
// which offers it on out_tvalid until out_tready takes it.
// A bank write takes effect at the moment its word moves to the output register,
// so the very next word already sees the new bank. Writes answer with target none.
// depends on cbm68_pkg, cbm68_regs, cbm68_lookup
module cartridge_bank_mapper_68 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // address[15:0], data[23:16]
  input  logic [1:0]  in_tuser,   // action[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // rom_address[21:0], ram_address[32:22], zero pad
  output logic [1:0]  out_tuser,  // target[1:0]
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);
  import cbm68_pkg::*;

  logic        s1_valid_r;
  action_t     s1_action_r;
  logic [15:0] s1_addr_r;
  logic [7:0]  s1_data_r;
  logic        out_valid_r;
  result_t     out_r;
  logic        advance;
  logic        in_fire;
  bank_state_t state;
  result_t     result;

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_action_r <= action_t'(in_tuser);
      s1_addr_r   <= in_tdata[15:0];
      s1_data_r   <= in_tdata[23:16];
    end
  end

  cbm68_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .wr_en       (s1_valid_r && advance && (s1_action_r == ACT_CPU_WRITE)),
    .wr_addr     (s1_addr_r),
    .wr_data     (s1_data_r),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .state       (state)
  );

  cbm68_lookup u_lookup (
    .action  (s1_action_r),
    .address (s1_addr_r),
    .state   (state),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.target;
  assign out_tdata  = {7'b0, out_r.ram_address, out_r.rom_address};

  a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> s1_valid_r)
    else $error("accepted word missing from input register");

  a_write_none: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && advance && s1_action_r == ACT_CPU_WRITE) |=>
      (out_valid_r && out_tuser == TGT_NONE))
    else $error("write produced a mapped result");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_tuser == TGT_NONE) |-> (out_tdata == '0))
    else $error("unmapped result carries address bits");

  a_rom_no_ram: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_tuser == TGT_PRG || out_tuser == TGT_CHR)) |->
      (out_r.ram_address == '0))
    else $error("rom result carries ram address");

  a_ram_no_rom: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_tuser == TGT_CIRAM) |-> (out_r.rom_address == '0))
    else $error("ram result carries rom address");

endmodule
